### src/tls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_pkg
// Shared constants, tables and types for the tilt levelling servo.
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_MAX = 24;

    localparam int LIMIT_W   = 23;
    localparam int GAIN_W    = 20;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SCALE = CFG_IDX_W'(1);

    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1000000);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(100000);

    localparam int OUT_W = 24;
    localparam int ANG_W = 24;
    localparam int ARC_W = 23;
    localparam logic [ARC_W-1:0] RIGHT_ANGLE = ARC_W'(5898240);

    // magnitudes handed to the arctangent unit, sized for the widest sample
    localparam int NUM_W   = SAMPLE_BITS_MAX + 12;
    localparam int SQ_W    = 62;
    localparam int ROOT_W  = 31;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;

    localparam int CORDIC_STEPS = 23;
    localparam int STEP_W       = 5;
    localparam int MIX_TERMS    = 13;
    localparam int TERM_W       = 4;
    localparam int COEF_W       = 12;
    localparam int SRC_W        = 4;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef struct packed {
        logic [SRC_W-1:0]         src;
        t_axis                    dst;
        logic signed [COEF_W-1:0] coef;
    } t_mix_term;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } t_atan_req;

    typedef struct packed {
        logic             done;
        logic [ARC_W-1:0] angle;
    } t_atan_rsp;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] val;
    } t_root_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_rsp;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ARC_W-1:0] arc_step(input logic [STEP_W-1:0] i);
        logic [ARC_W-1:0] t;
        case (i)
            5'd0:  t = ARC_W'(2949120);
            5'd1:  t = ARC_W'(1740967);
            5'd2:  t = ARC_W'(919879);
            5'd3:  t = ARC_W'(466945);
            5'd4:  t = ARC_W'(234379);
            5'd5:  t = ARC_W'(117304);
            5'd6:  t = ARC_W'(58666);
            5'd7:  t = ARC_W'(29335);
            5'd8:  t = ARC_W'(14668);
            5'd9:  t = ARC_W'(7334);
            5'd10: t = ARC_W'(3667);
            5'd11: t = ARC_W'(1833);
            5'd12: t = ARC_W'(917);
            5'd13: t = ARC_W'(458);
            5'd14: t = ARC_W'(229);
            5'd15: t = ARC_W'(115);
            5'd16: t = ARC_W'(57);
            5'd17: t = ARC_W'(29);
            5'd18: t = ARC_W'(14);
            5'd19: t = ARC_W'(7);
            5'd20: t = ARC_W'(4);
            5'd21: t = ARC_W'(2);
            5'd22: t = ARC_W'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

    // 120-degree mixing terms; samples ordered a0x a0y a0z a1x .. a2z
    function automatic t_mix_term mix_term(input logic [TERM_W-1:0] k);
        t_mix_term m;
        case (k)
            4'd0:  m = '{src: 4'd0, dst: AX_X, coef: -12'sd500};
            4'd1:  m = '{src: 4'd1, dst: AX_X, coef:  12'sd866};
            4'd2:  m = '{src: 4'd3, dst: AX_X, coef:  12'sd1000};
            4'd3:  m = '{src: 4'd6, dst: AX_X, coef: -12'sd500};
            4'd4:  m = '{src: 4'd7, dst: AX_X, coef: -12'sd866};
            4'd5:  m = '{src: 4'd0, dst: AX_Y, coef: -12'sd866};
            4'd6:  m = '{src: 4'd1, dst: AX_Y, coef: -12'sd500};
            4'd7:  m = '{src: 4'd4, dst: AX_Y, coef:  12'sd1000};
            4'd8:  m = '{src: 4'd6, dst: AX_Y, coef:  12'sd866};
            4'd9:  m = '{src: 4'd7, dst: AX_Y, coef: -12'sd500};
            4'd10: m = '{src: 4'd2, dst: AX_Z, coef: -12'sd1000};
            4'd11: m = '{src: 4'd5, dst: AX_Z, coef: -12'sd1000};
            4'd12: m = '{src: 4'd8, dst: AX_Z, coef: -12'sd1000};
            default: m = '{src: 4'd0, dst: AX_X, coef: 12'sd0};
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### src/tls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_in_if
// Sample channel: one beat carries a reading from all three sensors.
// ----------------------------------------------------------------------------
interface tls_in_if #(
    parameter int SAMPLE_BITS = tls_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] acc0_x;
    logic signed [SAMPLE_BITS-1:0] acc0_y;
    logic signed [SAMPLE_BITS-1:0] acc0_z;
    logic signed [SAMPLE_BITS-1:0] acc1_x;
    logic signed [SAMPLE_BITS-1:0] acc1_y;
    logic signed [SAMPLE_BITS-1:0] acc1_z;
    logic signed [SAMPLE_BITS-1:0] acc2_x;
    logic signed [SAMPLE_BITS-1:0] acc2_y;
    logic signed [SAMPLE_BITS-1:0] acc2_z;

    modport source (
        output valid, acc0_x, acc0_y, acc0_z, acc1_x, acc1_y, acc1_z,
               acc2_x, acc2_y, acc2_z,
        input  ready
    );
    modport sink (
        input  valid, acc0_x, acc0_y, acc0_z, acc1_x, acc1_y, acc1_z,
               acc2_x, acc2_y, acc2_z,
        output ready
    );
endinterface
`default_nettype wire

### src/tls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_out_if
// Result channel: actuator velocities, clamp flags and window means.
// ----------------------------------------------------------------------------
interface tls_out_if ();
    logic                            valid;
    logic                            ready;
    logic signed [tls_pkg::OUT_W-1:0] vel_act0;
    logic signed [tls_pkg::OUT_W-1:0] vel_act1;
    logic signed [tls_pkg::OUT_W-1:0] vel_act2;
    logic                            sat_act0;
    logic                            sat_act1;
    logic                            sat_act2;
    logic signed [tls_pkg::ANG_W-1:0] pitch_mean;
    logic signed [tls_pkg::ANG_W-1:0] roll_mean;

    modport source (
        output valid, vel_act0, vel_act1, vel_act2, sat_act0, sat_act1, sat_act2,
               pitch_mean, roll_mean,
        input  ready
    );
    modport sink (
        input  valid, vel_act0, vel_act1, vel_act2, sat_act0, sat_act1, sat_act2,
               pitch_mean, roll_mean,
        output ready
    );
endinterface
`default_nettype wire

### src/tls_root.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_root
// Bit-serial integer square root, floor result, one root bit per cycle.
// ----------------------------------------------------------------------------
module tls_root (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tls_pkg::t_root_req  i_req,
    output tls_pkg::t_root_rsp  o_rsp
);
    import tls_pkg::*;

    localparam int RW    = SQ_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [RW-1:0]     r_v;
    logic [RW-1:0]     r_r;
    logic [RW-1:0]     r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [ROOT_W-1:0] r_root;

    logic [RW-1:0] n_sum;
    logic          n_take;
    logic [RW-1:0] n_r;

    always_comb begin
        n_sum  = r_r + r_b;
        n_take = (r_v >= n_sum);
        n_r    = n_take ? ((r_r >> 1) + r_b) : (r_r >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_v     <= RW'(i_req.val);
                        r_r     <= '0;
                        r_b     <= RW'(1) << (2 * (ROOT_W - 1));
                        r_cnt   <= CNT_W'(ROOT_W - 1);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (n_take) begin
                        r_v <= r_v - n_sum;
                    end
                    r_r   <= n_r;
                    r_b   <= r_b >> 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_root  <= ROOT_W'(n_r);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = '{done: r_done, root: r_root};

endmodule
`default_nettype wire

### src/tls_atan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_atan
// First-quadrant arctangent of num/den by iterative CORDIC vectoring,
// with range normalisation ahead of the rotations.
// ----------------------------------------------------------------------------
module tls_atan (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tls_pkg::t_atan_req  i_req,
    output tls_pkg::t_atan_rsp  o_rsp
);
    import tls_pkg::*;

    localparam int XY_W = 35;
    localparam int Z_W  = 26;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK0,
        S_SHR,
        S_CHK1,
        S_SHL,
        S_ROT
    } t_state;

    t_state                  r_state;
    logic [NUM_W-1:0]        r_n;
    logic [NUM_W-1:0]        r_d;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [STEP_W-1:0]       r_i;
    logic                    r_done;
    logic [ARC_W-1:0]        r_angle;

    logic                    n_big;
    logic                    n_small;
    logic signed [XY_W-1:0]  n_dx;
    logic signed [XY_W-1:0]  n_dy;
    logic signed [Z_W-1:0]   n_t;
    logic signed [XY_W-1:0]  n_x;
    logic signed [XY_W-1:0]  n_y;
    logic signed [Z_W-1:0]   n_z;
    logic [ARC_W-1:0]        n_zc;

    always_comb begin
        n_big   = ((r_n | r_d) >> 31) != '0;
        n_small = ((r_n | r_d) >> 29) == '0;
        n_dx    = r_y >>> r_i;
        n_dy    = r_x >>> r_i;
        n_t     = Z_W'(arc_step(r_i));
        if (r_y >= 0) begin
            n_x = r_x + n_dx;
            n_y = r_y - n_dy;
            n_z = r_z + n_t;
        end else begin
            n_x = r_x - n_dx;
            n_y = r_y + n_dy;
            n_z = r_z - n_t;
        end
        if (n_z < 0) begin
            n_zc = '0;
        end else if (n_z > Z_W'(RIGHT_ANGLE)) begin
            n_zc = RIGHT_ANGLE;
        end else begin
            n_zc = ARC_W'(n_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_n     <= i_req.num;
                        r_d     <= i_req.den;
                        r_state <= S_CHK0;
                    end
                end
                S_CHK0, S_CHK1: begin
                    if (r_n == '0) begin
                        r_angle <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_d == '0) begin
                        r_angle <= RIGHT_ANGLE;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= (r_state == S_CHK0) ? S_SHR : S_SHL;
                    end
                end
                S_SHR: begin
                    if (n_big) begin
                        r_n <= r_n >> 1;
                        r_d <= r_d >> 1;
                    end else begin
                        r_state <= S_CHK1;
                    end
                end
                S_SHL: begin
                    if (n_small) begin
                        r_n <= r_n << 1;
                        r_d <= r_d << 1;
                    end else begin
                        r_x     <= XY_W'(r_d[30:0]);
                        r_y     <= XY_W'(r_n[30:0]);
                        r_z     <= '0;
                        r_i     <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    r_i <= r_i + 1'b1;
                    if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_angle <= n_zc;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = '{done: r_done, angle: r_angle};

endmodule
`default_nettype wire

### src/tilt_leveling_servo_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_leveling_servo_top
// Tilt levelling servo: mixes three accelerometer readings into a tilt
// vector, derives pitch and roll, averages them over a window and turns the
// means into three clamped actuator velocities.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time; i_in.ready is low while it is worked on
// and the result sits in an output register, so the next beat is taken even
// while a result waits. A beat passes through these steps in order: taking
// the beat, the mixing terms through the shared 32x32 multiplier, the
// magnitudes, range check and squares, the bit-serial root, the two CORDIC
// arctangent passes (23 rotations each plus range checks, with a shift step
// repeated while the operands are too large or too small), the history
// update, the two window means by reciprocal multiplication, the velocity
// products and the hand-over to the output register. The pitch and roll
// histories are cleared by reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module tilt_leveling_servo_top #(
    parameter int WINDOW      = tls_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tls_pkg::SAMPLE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    tls_in_if.sink                           i_in,
    tls_out_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [tls_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [tls_pkg::CFG_W-1:0]         i_cfg_data
);
    import tls_pkg::*;

    localparam int MIX_W   = SAMPLE_BITS + 12;
    localparam int SUM_W   = ANG_W + $clog2(WINDOW) + 1;
    localparam int T_W     = 28;
    localparam int SMP_N   = 9;
    // mean = (|sum| + WINDOW/2) * DIV_RECIP >> DIV_SH, exact for |sum| < 2^(SUM_W-1)
    localparam int     DIV_SH    = SUM_W - 1 + $clog2(WINDOW);
    localparam longint DIV_RECIP = ((longint'(1) << DIV_SH) + longint'(WINDOW) - 1)
                                   / longint'(WINDOW);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MIX,
        S_MACC,
        S_ABS,
        S_NORM,
        S_SQY,
        S_SQZ,
        S_SQS,
        S_ROOT,
        S_PITCH,
        S_ROLL,
        S_HIST,
        S_DLOAD,
        S_DIV,
        S_DEND,
        S_VMUL,
        S_VCLP,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [LIMIT_W-1:0]              r_limit;
    logic [GAIN_W-1:0]               r_gain;
    logic signed [SAMPLE_BITS-1:0]   r_smp [SMP_N];
    logic signed [MIX_W-1:0]         r_x;
    logic signed [MIX_W-1:0]         r_y;
    logic signed [MIX_W-1:0]         r_z;
    logic [MIX_W-1:0]                r_ax;
    logic [MIX_W-1:0]                r_ay;
    logic [MIX_W-1:0]                r_az;
    logic [TERM_W-1:0]               r_k;
    logic signed [PROD_W-1:0]        r_prod;
    logic [SQ_W-1:0]                 r_sq;
    logic signed [ANG_W-1:0]         r_pitch;
    logic signed [ANG_W-1:0]         r_roll;
    logic signed [ANG_W-1:0]         r_hp [WINDOW];
    logic signed [ANG_W-1:0]         r_hr [WINDOW];
    logic signed [SUM_W-1:0]         r_sum_p;
    logic signed [SUM_W-1:0]         r_sum_r;
    logic [SUM_W-1:0]                r_dq;
    logic                            r_div_roll;
    logic                            r_div_neg;
    logic signed [ANG_W-1:0]         r_pm;
    logic signed [ANG_W-1:0]         r_rm;
    logic signed [OUT_W-1:0]         r_vel [3];
    logic                            r_sat [3];
    logic                            r_atan_start;
    logic [NUM_W-1:0]                r_atan_num;
    logic [NUM_W-1:0]                r_atan_den;
    logic                            r_root_start;
    logic [SQ_W-1:0]                 r_root_val;
    logic                            r_out_valid;
    logic signed [OUT_W-1:0]         r_out_vel [3];
    logic                            r_out_sat [3];
    logic signed [ANG_W-1:0]         r_out_pm;
    logic signed [ANG_W-1:0]         r_out_rm;

    t_atan_req                       atan_req;
    t_atan_rsp                       atan_rsp;
    t_root_req                       root_req;
    t_root_rsp                       root_rsp;

    t_mix_term                       n_term;
    logic signed [MUL_W-1:0]         n_mul_a;
    logic signed [MUL_W-1:0]         n_mul_b;
    logic [MIX_W-1:0]                n_abs_y;
    logic [MIX_W-1:0]                n_abs_z;
    logic signed [T_W-1:0]           n_pe;
    logic signed [T_W-1:0]           n_p4;
    logic signed [T_W-1:0]           n_r7;
    logic signed [T_W-1:0]           n_t;
    logic [PROD_W-1:0]               n_mag;
    logic [PROD_W-1:0]               n_qm;
    logic                            n_over;
    logic [OUT_W-1:0]                n_qc;
    logic signed [SUM_W-1:0]         n_dsum;
    logic [ANG_W-1:0]                n_quo;
    logic                            n_load;

    assign atan_req = '{start: r_atan_start, num: r_atan_num, den: r_atan_den};
    assign root_req = '{start: r_root_start, val: r_root_val};

    tls_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (atan_req),
        .o_rsp   (atan_rsp)
    );

    tls_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    always_comb begin
        n_term  = mix_term(r_k);
        n_abs_y = (r_y < 0) ? MIX_W'(-r_y) : MIX_W'(r_y);
        n_abs_z = (r_z < 0) ? MIX_W'(-r_z) : MIX_W'(r_z);

        // velocity mix terms: -(4P-7R), 8P, -(4P+7R)
        n_pe = T_W'(r_pm);
        n_p4 = n_pe <<< 2;
        n_r7 = (T_W'(r_rm) <<< 3) - T_W'(r_rm);
        case (r_k[1:0])
            2'd0:    n_t = n_r7 - n_p4;
            2'd1:    n_t = n_pe <<< 3;
            2'd2:    n_t = -(n_p4 + n_r7);
            default: n_t = '0;
        endcase

        // shared multiplier operand select
        case (r_state)
            S_MIX: begin
                n_mul_a = MUL_W'(r_smp[n_term.src]);
                n_mul_b = MUL_W'(n_term.coef);
            end
            S_SQY: begin
                n_mul_a = MUL_W'(r_ay);
                n_mul_b = MUL_W'(r_ay);
            end
            S_SQZ: begin
                n_mul_a = MUL_W'(r_az);
                n_mul_b = MUL_W'(r_az);
            end
            S_DIV: begin
                n_mul_a = MUL_W'(r_dq);
                n_mul_b = MUL_W'(DIV_RECIP);
            end
            S_VMUL: begin
                n_mul_a = MUL_W'(r_gain);
                n_mul_b = MUL_W'(n_t);
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase

        // round half away from zero, then clamp on the magnitude
        n_mag  = (r_prod < 0) ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        n_qm   = (n_mag + PROD_W'(32768)) >> 16;
        n_over = n_qm > PROD_W'(r_limit);
        n_qc   = n_over ? OUT_W'(r_limit) : OUT_W'(n_qm);

        n_dsum = r_div_roll ? r_sum_r : r_sum_p;
        n_quo  = ANG_W'(r_prod >> DIV_SH);

        n_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_limit      <= LIMIT_RST;
            r_gain       <= GAIN_RST;
            r_sum_p      <= '0;
            r_sum_r      <= '0;
            r_atan_start <= 1'b0;
            r_root_start <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                r_hp[i] <= '0;
                r_hr[i] <= '0;
            end
        end else begin
            r_atan_start <= 1'b0;
            r_root_start <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAT_LIMIT:  r_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_GAIN_SCALE: r_gain  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_smp[0] <= i_in.acc0_x;
                        r_smp[1] <= i_in.acc0_y;
                        r_smp[2] <= i_in.acc0_z;
                        r_smp[3] <= i_in.acc1_x;
                        r_smp[4] <= i_in.acc1_y;
                        r_smp[5] <= i_in.acc1_z;
                        r_smp[6] <= i_in.acc2_x;
                        r_smp[7] <= i_in.acc2_y;
                        r_smp[8] <= i_in.acc2_z;
                        r_x      <= '0;
                        r_y      <= '0;
                        r_z      <= '0;
                        r_k      <= '0;
                        r_state  <= S_MIX;
                    end
                end
                S_MIX: r_state <= S_MACC;
                S_MACC: begin
                    case (n_term.dst)
                        AX_X:    r_x <= r_x + MIX_W'(r_prod);
                        AX_Y:    r_y <= r_y + MIX_W'(r_prod);
                        AX_Z:    r_z <= r_z + MIX_W'(r_prod);
                        default: ;
                    endcase
                    if (r_k == TERM_W'(MIX_TERMS - 1)) begin
                        r_state <= S_ABS;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MIX;
                    end
                end
                S_ABS: begin
                    r_ax    <= (r_x < 0) ? MIX_W'(-r_x) : MIX_W'(r_x);
                    r_ay    <= n_abs_y;
                    r_az    <= n_abs_z;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // bring all three below 2^30 so the squares fit
                    if (((r_ax | r_ay | r_az) >> 30) != '0) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                        r_az <= r_az >> 1;
                    end else begin
                        r_state <= S_SQY;
                    end
                end
                S_SQY: r_state <= S_SQZ;
                S_SQZ: begin
                    r_sq    <= SQ_W'(r_prod);
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    r_root_val   <= r_sq + SQ_W'(r_prod);
                    r_root_start <= 1'b1;
                    r_state      <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_rsp.done) begin
                        r_atan_num   <= NUM_W'(r_ax);
                        r_atan_den   <= NUM_W'(root_rsp.root);
                        r_atan_start <= 1'b1;
                        r_state      <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    if (atan_rsp.done) begin
                        r_pitch      <= (r_x > 0) ? -ANG_W'(atan_rsp.angle)
                                                  : ANG_W'(atan_rsp.angle);
                        r_atan_num   <= NUM_W'(n_abs_y);
                        r_atan_den   <= NUM_W'(n_abs_z);
                        r_atan_start <= 1'b1;
                        r_state      <= S_ROLL;
                    end
                end
                S_ROLL: begin
                    if (atan_rsp.done) begin
                        // zero Z counts as positive
                        if ((r_y > 0 && r_z >= 0) || (r_y < 0 && r_z < 0)) begin
                            r_roll <= -ANG_W'(atan_rsp.angle);
                        end else begin
                            r_roll <= ANG_W'(atan_rsp.angle);
                        end
                        r_state <= S_HIST;
                    end
                end
                S_HIST: begin
                    for (int i = 0; i < WINDOW - 1; i++) begin
                        r_hp[i] <= r_hp[i+1];
                        r_hr[i] <= r_hr[i+1];
                    end
                    r_hp[WINDOW-1] <= r_pitch;
                    r_hr[WINDOW-1] <= r_roll;
                    // running sums: drop the oldest entry, add the newest
                    r_sum_p    <= r_sum_p - SUM_W'(r_hp[0]) + SUM_W'(r_pitch);
                    r_sum_r    <= r_sum_r - SUM_W'(r_hr[0]) + SUM_W'(r_roll);
                    r_div_roll <= 1'b0;
                    r_state    <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_div_neg <= n_dsum < 0;
                    r_dq      <= ((n_dsum < 0) ? SUM_W'(-n_dsum) : SUM_W'(n_dsum))
                                 + SUM_W'(WINDOW / 2);
                    r_state   <= S_DIV;
                end
                // reciprocal product lands in r_prod
                S_DIV: r_state <= S_DEND;
                S_DEND: begin
                    if (r_div_roll) begin
                        r_rm    <= r_div_neg ? -n_quo : n_quo;
                        r_k     <= '0;
                        r_state <= S_VMUL;
                    end else begin
                        r_pm       <= r_div_neg ? -n_quo : n_quo;
                        r_div_roll <= 1'b1;
                        r_state    <= S_DLOAD;
                    end
                end
                S_VMUL: r_state <= S_VCLP;
                S_VCLP: begin
                    r_vel[r_k[1:0]] <= (r_prod < 0) ? -n_qc : n_qc;
                    r_sat[r_k[1:0]] <= n_over;
                    if (r_k[1:0] == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_VMUL;
                    end
                end
                S_DONE: begin
                    if (n_load) begin
                        r_out_vel <= r_vel;
                        r_out_sat <= r_sat;
                        r_out_pm  <= r_pm;
                        r_out_rm  <= r_rm;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.vel_act0   = r_out_vel[0];
    assign o_out.vel_act1   = r_out_vel[1];
    assign o_out.vel_act2   = r_out_vel[2];
    assign o_out.sat_act0   = r_out_sat[0];
    assign o_out.sat_act1   = r_out_sat[1];
    assign o_out.sat_act2   = r_out_sat[2];
    assign o_out.pitch_mean = r_out_pm;
    assign o_out.roll_mean  = r_out_rm;

endmodule
`default_nettype wire

### src/tls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_checker
// Port-level checks for the tilt levelling servo, bound to the top level.
// ----------------------------------------------------------------------------
module tls_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  wire signed [tls_pkg::OUT_W-1:0]  i_vel_act1,
    input  wire                              i_sat_act1,
    input  wire signed [tls_pkg::ANG_W-1:0]  i_pitch_mean,
    input  wire signed [tls_pkg::ANG_W-1:0]  i_roll_mean
);
    import tls_pkg::*;

    localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(RIGHT_ANGLE);

    // one sample set in flight: no second beat straight after a taken one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while a sample set is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pitch_mean <= ANG_MAX && i_pitch_mean >= -ANG_MAX
                      && i_roll_mean <= ANG_MAX && i_roll_mean >= -ANG_MAX))
        else $error("window mean beyond ninety degrees");

    a_level_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_pitch_mean == '0) |-> (i_vel_act1 == '0 && !i_sat_act1))
        else $error("actuator 1 driven with zero pitch");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tilt_leveling_servo_top tls_checker u_tls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_vel_act1   (o_out.vel_act1),
    .i_sat_act1   (o_out.sat_act1),
    .i_pitch_mean (o_out.pitch_mean),
    .i_roll_mean  (o_out.roll_mean)
);
`default_nettype wire
